>>> rtl/core/apmm_pkg.sv
// Shared types, constants and the control store of the attitude PD motor mixer.
// Used by apmm_sequencer, apmm_datapath and attitude_pd_motor_mixer.
// Depends on nothing.
package apmm_pkg;

   // Datapath widths.
   localparam int PROD_W  = 54;  // products, accumulator and motor forces; the last two in Q.32
   localparam int A_W     = 36;  // multiplier operand A, signed
   localparam int B_W     = 26;  // multiplier operand B, signed
   localparam int E_W     = 29;  // angle error, Q.24
   localparam int D_W     = 36;  // derivative error, Q.24
   localparam int TT_W    = 31;  // roll and pitch torque, Q.16
   localparam int TY_W    = 36;  // yaw torque, Q.16
   localparam int TM_W    = 49;  // roll and pitch mixer terms, Q.32
   localparam int ANG_W   = 16;
   localparam int TGT_W   = 13;
   localparam int BASE_W  = 9;
   localparam int CORR_W  = 10;
   localparam int COLL_W  = 11;  // 30 + base + correction
   localparam int MOTOR_W = 8;
   localparam int CSR_W   = 16;
   localparam int CSR_IDX_W = 3;
   localparam int STEP_W  = 5;

   // Arithmetic constants.
   localparam logic signed [B_W-1:0] DEG2RAD_Q30 = 26'sd18740330;
   localparam logic signed [B_W-1:0] YAW_MIX     = 26'sd123586;
   localparam logic signed [B_W-1:0] TILT_MIX    = 26'sd193893;
   localparam logic [MOTOR_W-1:0]    MOTOR_CAP   = 8'd240;
   localparam logic signed [TGT_W-1:0] TARGET_LIM = 13'sd3840;
   localparam logic signed [CSR_W-1:0] YAW_SP_LIM = 16'sd23040;
   localparam logic [BASE_W-1:0]     BASE_MAX    = 9'd460;
   localparam logic signed [CORR_W-1:0] CORR_MAX = 10'sd300;
   localparam logic signed [COLL_W:0] THRUST_BASELINE = 12'sd30;

   // Register reset values.
   localparam logic [CSR_W-1:0] ROLL_KP_RST  = 16'd5709;
   localparam logic [CSR_W-1:0] ROLL_KD_RST  = 16'd90;
   localparam logic [CSR_W-1:0] PITCH_KP_RST = 16'd5709;
   localparam logic [CSR_W-1:0] PITCH_KD_RST = 16'd90;
   localparam logic [CSR_W-1:0] YAW_KP_RST   = 16'd4608;
   localparam logic [CSR_W-1:0] YAW_KD_RST   = 16'd617;
   localparam logic [CSR_W-1:0] YAW_SP_RST   = 16'd0;

   // Register indexes.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ROLL_KP  = 3'd0,
      CSR_ROLL_KD  = 3'd1,
      CSR_PITCH_KP = 3'd2,
      CSR_PITCH_KD = 3'd3,
      CSR_YAW_KP   = 3'd4,
      CSR_YAW_KD   = 3'd5,
      CSR_YAW_SP   = 3'd6
   } csr_idx_type;

   typedef struct packed {
      logic [CSR_W-1:0]        roll_kp;
      logic [CSR_W-1:0]        roll_kd;
      logic [CSR_W-1:0]        pitch_kp;
      logic [CSR_W-1:0]        pitch_kd;
      logic [CSR_W-1:0]        yaw_kp;
      logic [CSR_W-1:0]        yaw_kd;
      logic signed [CSR_W-1:0] yaw_sp;
   } cfg_type;

   // Control word fields.
   typedef enum logic [3:0] {
      A_RTGT   = 4'd0,
      A_PTGT   = 4'd1,
      A_YSP    = 4'd2,
      A_RRATE  = 4'd3,
      A_PRATE  = 4'd4,
      A_ERR    = 4'd5,
      A_DER    = 4'd6,
      A_TROLL  = 4'd7,
      A_TPITCH = 4'd8,
      A_TYAW   = 4'd9
   } a_sel_type;

   typedef enum logic [3:0] {
      B_DEG      = 4'd0,
      B_ROLL_KP  = 4'd1,
      B_ROLL_KD  = 4'd2,
      B_PITCH_KP = 4'd3,
      B_PITCH_KD = 4'd4,
      B_YAW_KP   = 4'd5,
      B_YAW_KD   = 4'd6,
      B_TILT     = 4'd7,
      B_YAW_MIX  = 4'd8
   } b_sel_type;

   typedef enum logic [1:0] {
      E_NONE  = 2'd0,
      E_ROLL  = 2'd1,
      E_PITCH = 2'd2,
      E_YAW   = 2'd3
   } e_op_type;

   typedef enum logic [1:0] {
      D_NONE = 2'd0,
      D_RATE = 2'd1,
      D_YAW  = 2'd2
   } d_op_type;

   typedef enum logic [1:0] {
      ACC_HOLD = 2'd0,
      ACC_LOAD = 2'd1,
      ACC_ADD  = 2'd2
   } acc_op_type;

   typedef enum logic [1:0] {
      T_NONE  = 2'd0,
      T_ROLL  = 2'd1,
      T_PITCH = 2'd2,
      T_YAW   = 2'd3
   } t_op_type;

   typedef enum logic [1:0] {
      M_NONE  = 2'd0,
      M_ROLL  = 2'd1,
      M_PITCH = 2'd2,
      M_YAW   = 2'd3
   } mix_op_type;

   typedef enum logic [1:0] {
      J_NEXT     = 2'd0,
      J_WAIT_REQ = 2'd1,
      J_WAIT_RSP = 2'd2,
      J_RESTART  = 2'd3
   } jmp_type;

   typedef struct packed {
      a_sel_type  a_sel;
      b_sel_type  b_sel;
      e_op_type   e_op;
      d_op_type   d_op;
      acc_op_type acc_op;
      t_op_type   t_op;
      mix_op_type mix_op;
      jmp_type    jmp;
   } ctl_type;

   localparam ctl_type CTL_NOP = '{
      a_sel:  A_RTGT,
      b_sel:  B_DEG,
      e_op:   E_NONE,
      d_op:   D_NONE,
      acc_op: ACC_HOLD,
      t_op:   T_NONE,
      mix_op: M_NONE,
      jmp:    J_NEXT
   };

   localparam logic [STEP_W-1:0] STEP_IDLE = 5'd0;

   // Control store. The multiplier result of a step is consumed by the next
   // step, so a word issues at most one product and retires the previous one.
   function automatic ctl_type ucode_word(input logic [STEP_W-1:0] step);
      ctl_type w;
      w = CTL_NOP;
      unique case (step)
         5'd0: begin
            w.jmp = J_WAIT_REQ;
         end
         5'd1: begin
            w.a_sel = A_RTGT;   w.b_sel = B_DEG;
         end
         5'd2: begin
            w.a_sel = A_RRATE;  w.b_sel = B_DEG;
            w.e_op  = E_ROLL;
         end
         5'd3: begin
            w.a_sel = A_ERR;    w.b_sel = B_ROLL_KP;
            w.d_op  = D_RATE;
         end
         5'd4: begin
            w.a_sel = A_DER;    w.b_sel = B_ROLL_KD;
            w.acc_op = ACC_LOAD;
         end
         5'd5: begin
            w.a_sel = A_PTGT;   w.b_sel = B_DEG;
            w.acc_op = ACC_ADD;
         end
         5'd6: begin
            w.a_sel = A_PRATE;  w.b_sel = B_DEG;
            w.t_op  = T_ROLL;   w.e_op  = E_PITCH;
         end
         5'd7: begin
            w.a_sel = A_ERR;    w.b_sel = B_PITCH_KP;
            w.d_op  = D_RATE;
         end
         5'd8: begin
            w.a_sel = A_DER;    w.b_sel = B_PITCH_KD;
            w.acc_op = ACC_LOAD;
         end
         5'd9: begin
            w.a_sel = A_YSP;    w.b_sel = B_DEG;
            w.acc_op = ACC_ADD;
         end
         5'd10: begin
            w.a_sel = A_TROLL;  w.b_sel = B_TILT;
            w.t_op  = T_PITCH;  w.e_op  = E_YAW;   w.d_op = D_YAW;
         end
         5'd11: begin
            w.a_sel = A_ERR;    w.b_sel = B_YAW_KP;
            w.mix_op = M_ROLL;
         end
         5'd12: begin
            w.a_sel = A_DER;    w.b_sel = B_YAW_KD;
            w.acc_op = ACC_LOAD;
         end
         5'd13: begin
            w.a_sel = A_TPITCH; w.b_sel = B_TILT;
            w.acc_op = ACC_ADD;
         end
         5'd14: begin
            w.mix_op = M_PITCH; w.t_op = T_YAW;
         end
         5'd15: begin
            w.a_sel = A_TYAW;   w.b_sel = B_YAW_MIX;
         end
         5'd16: begin
            w.mix_op = M_YAW;
         end
         5'd17: begin
            w.jmp = J_WAIT_RSP;
         end
         default: begin
            w.jmp = J_RESTART;
         end
      endcase
      return w;
   endfunction

endpackage

>>> rtl/core/apmm_sequencer.sv
// Step counter of the motor mixer: walks the control store in apmm_pkg and
// takes its conditional jumps. Depends on apmm_pkg.
module apmm_sequencer
   import apmm_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    rsp_free,
   output logic    req_stall,
   output ctl_type ctl
);

   logic [STEP_W-1:0] step_ff;
   logic [STEP_W-1:0] step_in;

   // Current control word.
   assign ctl = ucode_word(step_ff);

   // A request is taken only in the wait step at the head of the program.
   assign req_stall = (ctl.jmp != J_WAIT_REQ);

   // Next step: fall through, hold on a wait condition, or restart.
   always_comb begin
      unique case (ctl.jmp)
         J_NEXT:     step_in = step_ff + STEP_W'(1);
         J_WAIT_REQ: step_in = req_valid ? step_ff + STEP_W'(1) : step_ff;
         J_WAIT_RSP: step_in = rsp_free ? STEP_IDLE : step_ff;
         J_RESTART:  step_in = STEP_IDLE;
         default:    step_in = STEP_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

>>> rtl/core/apmm_datapath.sv
// Datapath of the motor mixer: request capture, one shared multiplier,
// error, torque and mixer registers, and the result register.
// Depends on apmm_pkg; driven by the control word from apmm_sequencer.
module apmm_datapath
   import apmm_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  ctl_type                   ctl,
   input  cfg_type                   cfg,
   input  logic                      req_take,
   input  logic signed [ANG_W-1:0]   req_roll_angle,
   input  logic signed [ANG_W-1:0]   req_pitch_angle,
   input  logic signed [ANG_W-1:0]   req_yaw_angle,
   input  logic signed [ANG_W-1:0]   req_roll_rate,
   input  logic signed [ANG_W-1:0]   req_pitch_rate,
   input  logic signed [TGT_W-1:0]   req_roll_target,
   input  logic signed [TGT_W-1:0]   req_pitch_target,
   input  logic [BASE_W-1:0]         req_base_thrust,
   input  logic signed [CORR_W-1:0]  req_thrust_correction,
   input  logic                      req_run,
   input  logic                      rsp_stall,
   output logic                      rsp_free,
   output logic                      rsp_valid,
   output logic [MOTOR_W-1:0]        rsp_motor_front,
   output logic [MOTOR_W-1:0]        rsp_motor_right,
   output logic [MOTOR_W-1:0]        rsp_motor_back,
   output logic [MOTOR_W-1:0]        rsp_motor_left
);

   localparam logic signed [PROD_W-1:0] HALF_10 = PROD_W'(512);
   localparam logic signed [PROD_W-1:0] HALF_13 = PROD_W'(4096);
   localparam logic signed [PROD_W-1:0] HALF_14 = PROD_W'(8192);
   localparam logic signed [PROD_W-1:0] HALF_16 = PROD_W'(32768);
   localparam logic signed [COLL_W:0]   TRIM_FRONT = 12'sd4;
   localparam logic signed [COLL_W:0]   TRIM_RIGHT = 12'sd8;
   localparam logic signed [COLL_W:0]   TRIM_BACK  = -12'sd4;
   localparam logic signed [COLL_W:0]   TRIM_LEFT  = -12'sd8;

   // Integer part of a force, floored at zero, capped, and gated by run.
   function automatic logic [MOTOR_W-1:0] motor_cmd(input logic signed [PROD_W-1:0] f,
                                                    input logic run);
      logic [PROD_W-33:0] ip;
      ip = f[PROD_W-1:32];
      if (!run || f[PROD_W-1] || (f == '0)) begin
         return '0;
      end else if (ip > (PROD_W-32)'(MOTOR_CAP)) begin
         return MOTOR_CAP;
      end else begin
         return ip[MOTOR_W-1:0];
      end
   endfunction

   // Captured request.
   logic signed [ANG_W-1:0]  roll_ff, roll_in, pitch_ff, pitch_in, yaw_ff, yaw_in;
   logic signed [ANG_W-1:0]  rrate_ff, rrate_in, prate_ff, prate_in;
   logic signed [TGT_W-1:0]  rtgt_ff, rtgt_in, ptgt_ff, ptgt_in;
   logic signed [COLL_W-1:0] coll_ff, coll_in;
   logic                     run_ff, run_in;
   logic signed [ANG_W-1:0]  prev_yaw_ff, prev_yaw_in;

   // Working registers.
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [PROD_W-1:0] acc_ff, acc_in;
   logic signed [E_W-1:0]    err_ff, err_in;
   logic signed [D_W-1:0]    der_ff, der_in;
   logic signed [TT_W-1:0]   t_roll_ff, t_roll_in, t_pitch_ff, t_pitch_in;
   logic signed [TY_W-1:0]   t_yaw_ff, t_yaw_in;
   logic signed [TM_W-1:0]   m_roll_ff, m_roll_in, m_pitch_ff, m_pitch_in;
   logic signed [PROD_W-1:0] m_yaw_ff, m_yaw_in;

   // Result register.
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [MOTOR_W-1:0]       front_ff, front_in, right_ff, right_in;
   logic [MOTOR_W-1:0]       back_ff, back_in, left_ff, left_in;

   logic signed [TGT_W-1:0]  rtgt_sat, ptgt_sat;
   logic [BASE_W-1:0]        base_sat;
   logic signed [CORR_W-1:0] corr_sat;
   logic signed [COLL_W:0]   coll_sum;
   logic signed [CSR_W-1:0]  ysp_sat;
   logic signed [A_W-1:0]    opa;
   logic signed [B_W-1:0]    opb;
   logic signed [A_W+B_W-1:0] prod_full;
   logic signed [PROD_W-1:0] sum10, sum13, sum14, sum16;
   logic signed [PROD_W-1:0] rnd10, rnd13, rnd14, rnd16;
   logic signed [PROD_W-1:0] ang_ext, err_full, der_full;
   logic signed [ANG_W:0]    dyaw;
   logic signed [PROD_W-1:0] dyaw_ext;
   logic signed [PROD_W-1:0] f_front, f_right, f_back, f_left;
   logic signed [PROD_W-1:0] m_roll_ext, m_pitch_ext;
   logic                     publish;

   // Input saturation ahead of the capture registers.
   always_comb begin
      rtgt_sat = req_roll_target;
      if (req_roll_target > TARGET_LIM) begin
         rtgt_sat = TARGET_LIM;
      end else if (req_roll_target < -TARGET_LIM) begin
         rtgt_sat = -TARGET_LIM;
      end
      ptgt_sat = req_pitch_target;
      if (req_pitch_target > TARGET_LIM) begin
         ptgt_sat = TARGET_LIM;
      end else if (req_pitch_target < -TARGET_LIM) begin
         ptgt_sat = -TARGET_LIM;
      end
      base_sat = (req_base_thrust > BASE_MAX) ? BASE_MAX : req_base_thrust;
      corr_sat = (req_thrust_correction > CORR_MAX) ? CORR_MAX : req_thrust_correction;
      coll_sum = THRUST_BASELINE + signed'({3'b000, base_sat})
                 + (COLL_W+1)'(corr_sat);
   end

   // Yaw setpoint saturation.
   always_comb begin
      ysp_sat = cfg.yaw_sp;
      if (cfg.yaw_sp > YAW_SP_LIM) begin
         ysp_sat = YAW_SP_LIM;
      end else if (cfg.yaw_sp < -YAW_SP_LIM) begin
         ysp_sat = -YAW_SP_LIM;
      end
   end

   // Request capture.
   always_comb begin
      roll_in  = roll_ff;
      pitch_in = pitch_ff;
      yaw_in   = yaw_ff;
      rrate_in = rrate_ff;
      prate_in = prate_ff;
      rtgt_in  = rtgt_ff;
      ptgt_in  = ptgt_ff;
      coll_in  = coll_ff;
      run_in   = run_ff;
      if (req_take) begin
         roll_in  = req_roll_angle;
         pitch_in = req_pitch_angle;
         yaw_in   = req_yaw_angle;
         rrate_in = req_roll_rate;
         prate_in = req_pitch_rate;
         rtgt_in  = rtgt_sat;
         ptgt_in  = ptgt_sat;
         coll_in  = coll_sum[COLL_W-1:0];
         run_in   = req_run;
      end
   end

   // Multiplier operand selection.
   always_comb begin
      unique case (ctl.a_sel)
         A_RTGT:   opa = A_W'(rtgt_ff);
         A_PTGT:   opa = A_W'(ptgt_ff);
         A_YSP:    opa = A_W'(ysp_sat);
         A_RRATE:  opa = A_W'(rrate_ff);
         A_PRATE:  opa = A_W'(prate_ff);
         A_ERR:    opa = A_W'(err_ff);
         A_DER:    opa = A_W'(der_ff);
         A_TROLL:  opa = A_W'(t_roll_ff);
         A_TPITCH: opa = A_W'(t_pitch_ff);
         A_TYAW:   opa = A_W'(t_yaw_ff);
         default:  opa = '0;
      endcase
      unique case (ctl.b_sel)
         B_DEG:      opb = DEG2RAD_Q30;
         B_ROLL_KP:  opb = signed'({{(B_W-CSR_W){1'b0}}, cfg.roll_kp});
         B_ROLL_KD:  opb = signed'({{(B_W-CSR_W){1'b0}}, cfg.roll_kd});
         B_PITCH_KP: opb = signed'({{(B_W-CSR_W){1'b0}}, cfg.pitch_kp});
         B_PITCH_KD: opb = signed'({{(B_W-CSR_W){1'b0}}, cfg.pitch_kd});
         B_YAW_KP:   opb = signed'({{(B_W-CSR_W){1'b0}}, cfg.yaw_kp});
         B_YAW_KD:   opb = signed'({{(B_W-CSR_W){1'b0}}, cfg.yaw_kd});
         B_TILT:     opb = TILT_MIX;
         B_YAW_MIX:  opb = YAW_MIX;
         default:    opb = '0;
      endcase
      prod_full = opa * opb;
      prod_in   = prod_full[PROD_W-1:0];
   end

   // Round half up of the registered product and accumulator.
   always_comb begin
      sum10 = prod_ff + HALF_10;
      sum13 = prod_ff + HALF_13;
      sum14 = prod_ff + HALF_14;
      sum16 = acc_ff + HALF_16;
      rnd10 = sum10 >>> 10;
      rnd13 = sum13 >>> 13;
      rnd14 = sum14 >>> 14;
      rnd16 = sum16 >>> 16;
   end

   // Angle error: converted target minus measured angle, both Q.24.
   always_comb begin
      err_in   = err_ff;
      ang_ext  = PROD_W'(roll_ff);
      err_full = '0;
      unique case (ctl.e_op)
         E_ROLL: begin
            ang_ext  = PROD_W'(roll_ff);
            err_full = rnd14 - (ang_ext <<< 12);
            err_in   = err_full[E_W-1:0];
         end
         E_PITCH: begin
            ang_ext  = PROD_W'(pitch_ff);
            err_full = rnd14 - (ang_ext <<< 12);
            err_in   = err_full[E_W-1:0];
         end
         E_YAW: begin
            ang_ext  = PROD_W'(yaw_ff);
            err_full = rnd13 - (ang_ext <<< 12);
            err_in   = err_full[E_W-1:0];
         end
         default: begin
            err_in = err_ff;
         end
      endcase
   end

   // Derivative error: negated gyro rate, or negated yaw difference times
   // 100 * 4096, which is the shift sum 2^18 + 2^17 + 2^14.
   always_comb begin
      der_in      = der_ff;
      prev_yaw_in = prev_yaw_ff;
      dyaw        = (ANG_W+1)'(yaw_ff) - (ANG_W+1)'(prev_yaw_ff);
      dyaw_ext    = PROD_W'(dyaw);
      der_full    = '0;
      unique case (ctl.d_op)
         D_RATE: begin
            der_full = -rnd10;
            der_in   = der_full[D_W-1:0];
         end
         D_YAW: begin
            der_full    = -((dyaw_ext <<< 18) + (dyaw_ext <<< 17) + (dyaw_ext <<< 14));
            der_in      = der_full[D_W-1:0];
            prev_yaw_in = yaw_ff;
         end
         default: begin
            der_in = der_ff;
         end
      endcase
   end

   // Torque accumulation and rounding to Q.16.
   always_comb begin
      acc_in     = acc_ff;
      t_roll_in  = t_roll_ff;
      t_pitch_in = t_pitch_ff;
      t_yaw_in   = t_yaw_ff;
      unique case (ctl.acc_op)
         ACC_LOAD: acc_in = prod_ff;
         ACC_ADD:  acc_in = acc_ff + prod_ff;
         default:  acc_in = acc_ff;
      endcase
      unique case (ctl.t_op)
         T_ROLL:  t_roll_in  = rnd16[TT_W-1:0];
         T_PITCH: t_pitch_in = rnd16[TT_W-1:0];
         T_YAW:   t_yaw_in   = rnd16[TY_W-1:0];
         default: t_yaw_in   = t_yaw_ff;
      endcase
   end

   // Mixer terms, torque times mixer factor in Q.32.
   always_comb begin
      m_roll_in  = m_roll_ff;
      m_pitch_in = m_pitch_ff;
      m_yaw_in   = m_yaw_ff;
      unique case (ctl.mix_op)
         M_ROLL:  m_roll_in  = prod_ff[TM_W-1:0];
         M_PITCH: m_pitch_in = prod_ff[TM_W-1:0];
         M_YAW:   m_yaw_in   = prod_ff;
         default: m_yaw_in   = m_yaw_ff;
      endcase
   end

   // Plus-configuration motor forces, collective thrust and trim in Q.32.
   always_comb begin
      m_roll_ext  = PROD_W'(m_roll_ff);
      m_pitch_ext = PROD_W'(m_pitch_ff);
      f_front = (PROD_W'((COLL_W+1)'(coll_ff) + TRIM_FRONT) <<< 30) - m_yaw_ff + m_pitch_ext;
      f_right = (PROD_W'((COLL_W+1)'(coll_ff) + TRIM_RIGHT) <<< 30) + m_yaw_ff - m_roll_ext;
      f_back  = (PROD_W'((COLL_W+1)'(coll_ff) + TRIM_BACK) <<< 30) - m_yaw_ff - m_pitch_ext;
      f_left  = (PROD_W'((COLL_W+1)'(coll_ff) + TRIM_LEFT) <<< 30) + m_yaw_ff + m_roll_ext;
   end

   // Result register: loaded in the last step once the slot is free.
   assign rsp_free = !rsp_valid_ff || !rsp_stall;
   assign publish  = (ctl.jmp == J_WAIT_RSP) && rsp_free;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      front_in     = front_ff;
      right_in     = right_ff;
      back_in      = back_ff;
      left_in      = left_ff;
      if (publish) begin
         rsp_valid_in = 1'b1;
         front_in     = motor_cmd(f_front, run_ff);
         right_in     = motor_cmd(f_right, run_ff);
         back_in      = motor_cmd(f_back, run_ff);
         left_in      = motor_cmd(f_left, run_ff);
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         prev_yaw_ff  <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         prev_yaw_ff  <= prev_yaw_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      roll_ff    <= roll_in;
      pitch_ff   <= pitch_in;
      yaw_ff     <= yaw_in;
      rrate_ff   <= rrate_in;
      prate_ff   <= prate_in;
      rtgt_ff    <= rtgt_in;
      ptgt_ff    <= ptgt_in;
      coll_ff    <= coll_in;
      run_ff     <= run_in;
      prod_ff    <= prod_in;
      acc_ff     <= acc_in;
      err_ff     <= err_in;
      der_ff     <= der_in;
      t_roll_ff  <= t_roll_in;
      t_pitch_ff <= t_pitch_in;
      t_yaw_ff   <= t_yaw_in;
      m_roll_ff  <= m_roll_in;
      m_pitch_ff <= m_pitch_in;
      m_yaw_ff   <= m_yaw_in;
      front_ff   <= front_in;
      right_ff   <= right_in;
      back_ff    <= back_in;
      left_ff    <= left_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_motor_front = front_ff;
   assign rsp_motor_right = right_ff;
   assign rsp_motor_back  = back_ff;
   assign rsp_motor_left  = left_ff;

endmodule

>>> rtl/core/attitude_pd_motor_mixer.sv
// Top level of the attitude PD controller with plus-configuration motor mixer.
// Holds the gain registers and joins apmm_sequencer and apmm_datapath.
// Depends on apmm_pkg.

// Each request (one control tick) occupies one wait step that takes the
// request plus seventeen steps of a microprogram that runs every
// product through one shared 36 x 26 bit multiplier, one product per cycle.
// The result register is loaded in the last step of the program, and a new
// request is accepted only once the previous program is through. The result
// sits in an output register, and a new request is taken as soon as the
// program is back in its wait step, even while the previous result is still
// waiting to be taken; the last step holds only while that output register is
// still full and stalled. Gains and the yaw setpoint are written through the
// csr_ port and should be changed only while no request is in flight. The
// stored previous yaw angle is cleared by reset and updated on every request,
// whether run is set or not.
module attitude_pd_motor_mixer
   import apmm_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic signed [ANG_W-1:0]   req_roll_angle,
   input  logic signed [ANG_W-1:0]   req_pitch_angle,
   input  logic signed [ANG_W-1:0]   req_yaw_angle,
   input  logic signed [ANG_W-1:0]   req_roll_rate,
   input  logic signed [ANG_W-1:0]   req_pitch_rate,
   input  logic signed [TGT_W-1:0]   req_roll_target,
   input  logic signed [TGT_W-1:0]   req_pitch_target,
   input  logic [BASE_W-1:0]         req_base_thrust,
   input  logic signed [CORR_W-1:0]  req_thrust_correction,
   input  logic                      req_run,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [MOTOR_W-1:0]        rsp_motor_front,
   output logic [MOTOR_W-1:0]        rsp_motor_right,
   output logic [MOTOR_W-1:0]        rsp_motor_back,
   output logic [MOTOR_W-1:0]        rsp_motor_left,
   input  logic                      csr_wr_en,
   input  logic [CSR_IDX_W-1:0]      csr_index,
   input  logic [CSR_W-1:0]          csr_wr_data
);

   cfg_type cfg_ff;
   cfg_type cfg_in;
   ctl_type ctl;
   logic    rsp_free;
   logic    req_take;

   // Configuration registers; an unknown index is ignored.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_ROLL_KP:  cfg_in.roll_kp  = csr_wr_data;
            CSR_ROLL_KD:  cfg_in.roll_kd  = csr_wr_data;
            CSR_PITCH_KP: cfg_in.pitch_kp = csr_wr_data;
            CSR_PITCH_KD: cfg_in.pitch_kd = csr_wr_data;
            CSR_YAW_KP:   cfg_in.yaw_kp   = csr_wr_data;
            CSR_YAW_KD:   cfg_in.yaw_kd   = csr_wr_data;
            CSR_YAW_SP:   cfg_in.yaw_sp   = signed'(csr_wr_data);
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.roll_kp  <= ROLL_KP_RST;
         cfg_ff.roll_kd  <= ROLL_KD_RST;
         cfg_ff.pitch_kp <= PITCH_KP_RST;
         cfg_ff.pitch_kd <= PITCH_KD_RST;
         cfg_ff.yaw_kp   <= YAW_KP_RST;
         cfg_ff.yaw_kd   <= YAW_KD_RST;
         cfg_ff.yaw_sp   <= signed'(YAW_SP_RST);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Request handshake.
   assign req_take = req_valid && !req_stall;

   apmm_sequencer u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .rsp_free  (rsp_free),
      .req_stall (req_stall),
      .ctl       (ctl)
   );

   apmm_datapath u_dp (
      .clock                 (clock),
      .reset                 (reset),
      .ctl                   (ctl),
      .cfg                   (cfg_ff),
      .req_take              (req_take),
      .req_roll_angle        (req_roll_angle),
      .req_pitch_angle       (req_pitch_angle),
      .req_yaw_angle         (req_yaw_angle),
      .req_roll_rate         (req_roll_rate),
      .req_pitch_rate        (req_pitch_rate),
      .req_roll_target       (req_roll_target),
      .req_pitch_target      (req_pitch_target),
      .req_base_thrust       (req_base_thrust),
      .req_thrust_correction (req_thrust_correction),
      .req_run               (req_run),
      .rsp_stall             (rsp_stall),
      .rsp_free              (rsp_free),
      .rsp_valid             (rsp_valid),
      .rsp_motor_front       (rsp_motor_front),
      .rsp_motor_right       (rsp_motor_right),
      .rsp_motor_back        (rsp_motor_back),
      .rsp_motor_left        (rsp_motor_left)
   );

   // A taken request keeps the input side closed while the program runs.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while the program was not idle");

   // Every motor command respects the cap.
   a_motor_cap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_motor_front <= MOTOR_CAP) && (rsp_motor_right <= MOTOR_CAP)
                    && (rsp_motor_back <= MOTOR_CAP) && (rsp_motor_left <= MOTOR_CAP))
      else $error("motor command above cap");

   // A new result only comes out of a running program.
   a_result_from_program: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result appeared without a request in flight");

endmodule

>>> verif/tb.sv
// Self-checking testbench for attitude_pd_motor_mixer: drives control ticks, predicts
// the four motor commands in fixed point and scores every result in order.
// Depends on apmm_pkg and the attitude_pd_motor_mixer RTL.
module tb;
   import apmm_pkg::*;

   localparam int HALF_PERIOD     = 6;
   localparam int RESET_CYCLES    = 12;
   localparam int SETTLE_CYCLES   = 40;
   localparam int HOLD_CYCLES     = 300;
   localparam int WATCHDOG_LIMIT  = 3000;
   localparam int REPORT_LIMIT    = 10;

   // Fixed-point factors of the control law.
   localparam longint DEG_TO_RAD_Q30  = 18740330;
   localparam longint YAW_MIX_Q16     = 123586;
   localparam longint TILT_MIX_Q16    = 193893;
   localparam longint THRUST_IDLE     = 30;
   localparam longint THRUST_BASE_TOP = 460;
   localparam longint THRUST_CORR_TOP = 300;
   localparam longint TARGET_TOP      = 3840;
   localparam longint YAW_SP_TOP      = 23040;
   localparam longint MOTOR_TOP       = 240;
   localparam longint YAW_RATE_SCALE  = 100;

   // An index with no register behind it.
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_IDX = 3'd7;

   typedef struct packed {
      logic signed [15:0] roll_angle;
      logic signed [15:0] pitch_angle;
      logic signed [15:0] yaw_angle;
      logic signed [15:0] roll_rate;
      logic signed [15:0] pitch_rate;
      logic signed [12:0] roll_target;
      logic signed [12:0] pitch_target;
      logic [8:0]         base_thrust;
      logic signed [9:0]  thrust_correction;
      logic               run;
   } tick_type;

   typedef struct packed {
      logic [7:0] front;
      logic [7:0] right;
      logic [7:0] back;
      logic [7:0] left;
   } motors_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic signed [ANG_W-1:0]  req_roll_angle = '0;
   logic signed [ANG_W-1:0]  req_pitch_angle = '0;
   logic signed [ANG_W-1:0]  req_yaw_angle = '0;
   logic signed [ANG_W-1:0]  req_roll_rate = '0;
   logic signed [ANG_W-1:0]  req_pitch_rate = '0;
   logic signed [TGT_W-1:0]  req_roll_target = '0;
   logic signed [TGT_W-1:0]  req_pitch_target = '0;
   logic [BASE_W-1:0]        req_base_thrust = '0;
   logic signed [CORR_W-1:0] req_thrust_correction = '0;
   logic                     req_run = 1'b0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic [MOTOR_W-1:0]       rsp_motor_front;
   logic [MOTOR_W-1:0]       rsp_motor_right;
   logic [MOTOR_W-1:0]       rsp_motor_back;
   logic [MOTOR_W-1:0]       rsp_motor_left;
   logic                     csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]     csr_index = '0;
   logic [CSR_W-1:0]         csr_wr_data = '0;

   // Shadow copy of the registers and of the stored yaw angle.
   cfg_type            gain_regs;
   logic signed [15:0] last_yaw;

   motors_type expected_motors [$];
   int      gap_pct = 0;
   int      stall_pct = 0;
   int      hold_requests = 0;
   int      holds_served = 0;
   int      hold_left = 0;
   int      ticks_sent = 0;
   int      results_seen = 0;
   int      settings_used = 0;
   int      mismatches = 0;

   attitude_pd_motor_mixer dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_roll_angle        (req_roll_angle),
      .req_pitch_angle       (req_pitch_angle),
      .req_yaw_angle         (req_yaw_angle),
      .req_roll_rate         (req_roll_rate),
      .req_pitch_rate        (req_pitch_rate),
      .req_roll_target       (req_roll_target),
      .req_pitch_target      (req_pitch_target),
      .req_base_thrust       (req_base_thrust),
      .req_thrust_correction (req_thrust_correction),
      .req_run               (req_run),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_motor_front       (rsp_motor_front),
      .rsp_motor_right       (rsp_motor_right),
      .rsp_motor_back        (rsp_motor_back),
      .rsp_motor_left        (rsp_motor_left),
      .csr_wr_en             (csr_wr_en),
      .csr_index             (csr_index),
      .csr_wr_data           (csr_wr_data)
   );

   always #HALF_PERIOD clock = ~clock;

   function automatic longint clamp(input longint v, input longint lo, input longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   // Add half an LSB, then shift right arithmetically: rounds half up.
   function automatic longint round_shift(input longint x, input int n);
      return (x + (longint'(1) <<< (n - 1))) >>> n;
   endfunction

   // Integer part of a positive Q.32 force, capped; zero when not running.
   function automatic logic [7:0] motor_command(input longint force_q32, input logic run);
      longint whole;
      if (!run || force_q32 <= 0) return 8'd0;
      whole = force_q32 >>> 32;
      if (whole > MOTOR_TOP) whole = MOTOR_TOP;
      return 8'(whole);
   endfunction

   // PD torques on roll, pitch and yaw, then the plus-configuration mix.
   function automatic motors_type predict_motors(input tick_type t);
      motors_type m;
      longint roll, pitch, yaw, rrate, prate, rtgt, ptgt, base, corr, ysp, prev;
      longint e_roll, e_pitch, e_yaw, d_roll, d_pitch, d_yaw;
      longint t_roll, t_pitch, t_yaw, coll, yaw_mix, roll_mix, pitch_mix, one;
      roll  = longint'($signed(t.roll_angle));
      pitch = longint'($signed(t.pitch_angle));
      yaw   = longint'($signed(t.yaw_angle));
      rrate = longint'($signed(t.roll_rate));
      prate = longint'($signed(t.pitch_rate));
      rtgt  = clamp(longint'($signed(t.roll_target)), -TARGET_TOP, TARGET_TOP);
      ptgt  = clamp(longint'($signed(t.pitch_target)), -TARGET_TOP, TARGET_TOP);
      base  = clamp(longint'(t.base_thrust), 0, THRUST_BASE_TOP);
      corr  = clamp(longint'($signed(t.thrust_correction)), -512, THRUST_CORR_TOP);
      ysp   = clamp(longint'($signed(gain_regs.yaw_sp)), -YAW_SP_TOP, YAW_SP_TOP);
      prev  = longint'(last_yaw);

      // Errors in Q.24 radians.
      e_roll  = round_shift(rtgt * DEG_TO_RAD_Q30, 14) - roll * 4096;
      e_pitch = round_shift(ptgt * DEG_TO_RAD_Q30, 14) - pitch * 4096;
      e_yaw   = round_shift(ysp * DEG_TO_RAD_Q30, 13) - yaw * 4096;
      d_roll  = -round_shift(rrate * DEG_TO_RAD_Q30, 10);
      d_pitch = -round_shift(prate * DEG_TO_RAD_Q30, 10);
      d_yaw   = -((yaw - prev) * YAW_RATE_SCALE * 4096);

      // Torques in Q.16.
      t_roll  = round_shift(longint'(gain_regs.roll_kp) * e_roll
                            + longint'(gain_regs.roll_kd) * d_roll, 16);
      t_pitch = round_shift(longint'(gain_regs.pitch_kp) * e_pitch
                            + longint'(gain_regs.pitch_kd) * d_pitch, 16);
      t_yaw   = round_shift(longint'(gain_regs.yaw_kp) * e_yaw
                            + longint'(gain_regs.yaw_kd) * d_yaw, 16);

      // Forces in Q.32; the collective term carries a factor of one quarter.
      one       = longint'(1) <<< 32;
      coll      = (THRUST_IDLE + base + corr) * (longint'(1) <<< 30);
      yaw_mix   = t_yaw * YAW_MIX_Q16;
      roll_mix  = t_roll * TILT_MIX_Q16;
      pitch_mix = t_pitch * TILT_MIX_Q16;
      m.front = motor_command(coll - yaw_mix + pitch_mix + one, t.run);
      m.right = motor_command(coll + yaw_mix - roll_mix + 2 * one, t.run);
      m.back  = motor_command(coll - yaw_mix - pitch_mix - one, t.run);
      m.left  = motor_command(coll + yaw_mix + roll_mix - 2 * one, t.run);
      return m;
   endfunction

   // Mostly plausible flight values around the last yaw; the rest uses full field ranges.
   function automatic tick_type random_tick();
      tick_type     t;
      logic [127:0] raw;
      if ($urandom_range(99) < 65) begin
         t.roll_angle   = 16'(int'($urandom_range(0, 1600)) - 800);
         t.pitch_angle  = 16'(int'($urandom_range(0, 1600)) - 800);
         t.yaw_angle    = 16'(int'(last_yaw) + int'($urandom_range(0, 400)) - 200);
         t.roll_rate    = 16'(int'($urandom_range(0, 3200)) - 1600);
         t.pitch_rate   = 16'(int'($urandom_range(0, 3200)) - 1600);
         t.roll_target  = 13'(int'($urandom_range(0, 7680)) - 3840);
         t.pitch_target = 13'(int'($urandom_range(0, 7680)) - 3840);
         t.base_thrust  = 9'($urandom_range(0, 250));
         t.thrust_correction = 10'(int'($urandom_range(0, 200)) - 100);
         t.run          = ($urandom_range(99) < 90);
      end else begin
         raw = {$urandom(), $urandom(), $urandom(), $urandom()};
         t   = raw[$bits(tick_type)-1:0];
      end
      return t;
   endfunction

   // Offer one request, after a random gap, and record its expected motors on acceptance.
   task automatic send_tick(input tick_type t);
      @(negedge clock);
      if (gap_pct != 0) begin
         while ($urandom_range(99) < gap_pct) begin
            req_valid = 1'b0;
            @(negedge clock);
         end
      end
      req_roll_angle        = t.roll_angle;
      req_pitch_angle       = t.pitch_angle;
      req_yaw_angle         = t.yaw_angle;
      req_roll_rate         = t.roll_rate;
      req_pitch_rate        = t.pitch_rate;
      req_roll_target       = t.roll_target;
      req_pitch_target      = t.pitch_target;
      req_base_thrust       = t.base_thrust;
      req_thrust_correction = t.thrust_correction;
      req_run               = t.run;
      req_valid             = 1'b1;
      do @(posedge clock); while (req_stall);
      expected_motors.push_back(predict_motors(t));
      last_yaw = t.yaw_angle;
      ticks_sent++;
   endtask

   task automatic send_fields(input int roll, pitch, yaw, rrate, prate,
                              input int rtgt, ptgt, base, corr, input bit run);
      tick_type t;
      t.roll_angle        = 16'(roll);
      t.pitch_angle       = 16'(pitch);
      t.yaw_angle         = 16'(yaw);
      t.roll_rate         = 16'(rrate);
      t.pitch_rate        = 16'(prate);
      t.roll_target       = 13'(rtgt);
      t.pitch_target      = 13'(ptgt);
      t.base_thrust       = 9'(base);
      t.thrust_correction = 10'(corr);
      t.run               = run;
      send_tick(t);
   endtask

   // Stop offering, then wait for every expected result and a little more.
   task automatic wait_results_drained();
      @(negedge clock);
      req_valid = 1'b0;
      while (expected_motors.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_W-1:0] value);
      @(negedge clock);
      csr_wr_en   = 1'b1;
      csr_index   = idx;
      csr_wr_data = value;
      @(negedge clock);
      csr_wr_en   = 1'b0;
      case (idx)
         CSR_ROLL_KP:  gain_regs.roll_kp  = value;
         CSR_ROLL_KD:  gain_regs.roll_kd  = value;
         CSR_PITCH_KP: gain_regs.pitch_kp = value;
         CSR_PITCH_KD: gain_regs.pitch_kd = value;
         CSR_YAW_KP:   gain_regs.yaw_kp   = value;
         CSR_YAW_KD:   gain_regs.yaw_kd   = value;
         CSR_YAW_SP:   gain_regs.yaw_sp   = value;
         default: ;
      endcase
   endtask

   task automatic apply_settings(input int kp_r, kd_r, kp_p, kd_p, kp_y, kd_y, yaw_sp);
      wait_results_drained();
      write_reg(CSR_ROLL_KP,  16'(kp_r));
      write_reg(CSR_ROLL_KD,  16'(kd_r));
      write_reg(CSR_PITCH_KP, 16'(kp_p));
      write_reg(CSR_PITCH_KD, 16'(kd_p));
      write_reg(CSR_YAW_KP,   16'(kp_y));
      write_reg(CSR_YAW_KD,   16'(kd_y));
      write_reg(CSR_YAW_SP,   16'(yaw_sp));
      settings_used++;
   endtask

   // Moderate gains keep most motor commands off the rails; wide ones use any value.
   task automatic random_settings(input bit wide);
      if (wide)
         apply_settings($urandom_range(0, 65535), $urandom_range(0, 65535),
                        $urandom_range(0, 65535), $urandom_range(0, 65535),
                        $urandom_range(0, 65535), $urandom_range(0, 65535),
                        $urandom_range(0, 65535));
      else
         apply_settings($urandom_range(0, 12000), $urandom_range(0, 1200),
                        $urandom_range(0, 12000), $urandom_range(0, 1200),
                        $urandom_range(0, 9000), $urandom_range(0, 1500),
                        int'($urandom_range(0, 46080)) - 23040);
   endtask

   task automatic run_phase(input int count, input int gaps, input int stalls, input bit wide);
      random_settings(wide);
      gap_pct   = gaps;
      stall_pct = stalls;
      repeat (count) send_tick(random_tick());
   endtask

   // Field extremes, saturation edges and run off under the reset gains.
   task automatic test_reset_values();
      send_fields(0, 0, 0, 0, 0, 0, 0, 0, 0, 1);
      send_fields(300, -200, 100, 160, -320, 1280, -640, 120, -20, 1);
      send_fields(-500, 400, 900, -800, 640, -2560, 2560, 200, 50, 0);
      send_fields(50, -50, 950, 0, 0, 0, 0, 150, 0, 1);
      send_fields(32767, 32767, -32768, -32768, -32768, 4095, 4095, 511, 511, 1);
      send_fields(-32768, -32768, 32767, 32767, 32767, -4096, -4096, 0, -512, 1);
      send_fields(0, 0, -32768, 0, 0, 3840, -3840, 460, 300, 1);
      send_fields(0, 0, 0, 0, 0, 3841, -3841, 461, 301, 1);
      send_fields(0, 0, 0, 0, 0, 0, 0, 511, -1, 0);
      send_fields(100, 100, 0, 0, 0, 0, 0, 0, -512, 1);
      send_fields(0, 0, 0, 0, 0, 0, 0, 460, 300, 1);
   endtask

   // Register extremes, an out-of-range yaw setpoint and a write to a spare index.
   task automatic test_register_extremes();
      apply_settings(0, 0, 0, 0, 0, 0, 23040);
      repeat (3) send_tick(random_tick());
      apply_settings(65535, 65535, 65535, 65535, 65535, 65535, -32768);
      repeat (3) send_tick(random_tick());
      apply_settings(5709, 90, 5709, 90, 4608, 617, 32767);
      write_reg(CSR_SPARE_IDX, 16'hFFFF);
      repeat (3) send_tick(random_tick());
      apply_settings(5709, 90, 5709, 90, 4608, 617, -23040);
      repeat (2) send_tick(random_tick());
   endtask

   task automatic test_streaming();
      run_phase(300, 0, 0, 1'b0);
   endtask

   task automatic test_sender_gaps();
      run_phase(220, 73, 0, 1'b0);
   endtask

   task automatic test_receiver_stalls();
      run_phase(220, 0, 73, 1'b0);
   endtask

   task automatic test_mixed_idling();
      run_phase(110, 34, 34, 1'b1);
      run_phase(110, 34, 34, 1'b0);
   endtask

   // The receiver holds off for a long stretch while requests keep coming.
   task automatic test_output_holdoff();
      random_settings(1'b0);
      gap_pct   = 0;
      stall_pct = 0;
      hold_requests++;
      repeat (40) send_tick(random_tick());
      stall_pct = 34;
      repeat (20) send_tick(random_tick());
   endtask

   // Short bursts, each followed by a pause until every result is back.
   task automatic test_drain_pause();
      random_settings(1'b0);
      gap_pct   = 0;
      stall_pct = 34;
      repeat (10) begin
         repeat (10) send_tick(random_tick());
         wait_results_drained();
      end
   endtask

   // Receiver stall pattern, with an occasional long hold-off on request.
   always @(negedge clock) begin
      if (holds_served != hold_requests) begin
         holds_served = hold_requests;
         hold_left    = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_stall = 1'b1;
      end else begin
         rsp_stall = (stall_pct != 0) && ($urandom_range(99) < stall_pct);
      end
   end

   task automatic check_field(input string name, input logic [7:0] want, got);
      if (got !== want) begin
         mismatches++;
         if (mismatches <= REPORT_LIMIT)
            $display("Mismatch on %s in result %0d: expected %0d, got %0d",
                     name, results_seen, want, got);
      end
   endtask

   // Score each accepted result against the oldest expectation.
   always @(posedge clock) begin : score_results
      motors_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
         if (expected_motors.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("Unexpected result %0d: motors %0d %0d %0d %0d", results_seen,
                        rsp_motor_front, rsp_motor_right, rsp_motor_back, rsp_motor_left);
         end else begin
            want = expected_motors.pop_front();
            check_field("motor_front", want.front, rsp_motor_front);
            check_field("motor_right", want.right, rsp_motor_right);
            check_field("motor_back",  want.back,  rsp_motor_back);
            check_field("motor_left",  want.left,  rsp_motor_left);
         end
         results_seen++;
      end
   end

   // Watchdog: ends the run after too many cycles with no request or result moving.
   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("Timeout: no progress for %0d cycles", WATCHDOG_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      gain_regs.roll_kp  = 16'd5709;
      gain_regs.roll_kd  = 16'd90;
      gain_regs.pitch_kp = 16'd5709;
      gain_regs.pitch_kd = 16'd90;
      gain_regs.yaw_kp   = 16'd4608;
      gain_regs.yaw_kd   = 16'd617;
      gain_regs.yaw_sp   = 16'sd0;
      last_yaw           = 16'sd0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_values();
      test_register_extremes();
      test_streaming();
      test_sender_gaps();
      test_receiver_stalls();
      test_mixed_idling();
      test_output_holdoff();
      test_drain_pause();
      wait_results_drained();

      if (expected_motors.size() != 0) begin
         mismatches++;
         $display("%0d expected results never arrived", expected_motors.size());
      end
      $display("Covered %0d control ticks and %0d results under %0d register settings.",
               ticks_sent, results_seen, settings_used);
      $display("Traffic mixed streaming, sender gaps, receiver stalls and a %0d-cycle hold-off.",
               HOLD_CYCLES);
      if (mismatches == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
